>>> design/msba_pkg.sv
// Shared types and constants for the multi-area slot bitmap allocator.
package msba_pkg;

  localparam int SLOTS_W    = 13;
  localparam int REG_AREAS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int AREA_CNT_W = 3;
  localparam int STATUS_W   = 3;
  localparam int AREA_IDX_W = 2;
  localparam int SLOT_IDX_W = 12;
  localparam int TOTAL_W    = 15;
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA0_SLOTS = 3'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DISABLED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD_AREA  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_SLOT  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC = 3'd5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic                                enable;
    logic [AREA_CNT_W-1:0]               area_count;
    logic [REG_AREAS-1:0][SLOTS_W-1:0]   slots;
  } cfg_regs_t;

endpackage

>>> design/multi_area_slot_bitmap_allocator.sv
// Multi-area first-fit slot allocator: sequencer, used counts and bitmap scan.
// One item at a time; an allocate scans the bitmap one 32-bit word per cycle through
// the single RAM read port. The next start is taken in the cycle of the out_valid
// strobe when no clearing pass is pending. Reset clears controls and runs a bitmap
// clearing pass over every area; writing an area's slot count clears that area.
// busy is high during either pass; results cannot be stalled by the receiver.
module multi_area_slot_bitmap_allocator import msba_pkg::*; #(
  parameter int NUM_AREAS = 4,
  parameter int MAX_SLOTS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [AREA_IDX_W-1:0] in_area_index,
  input  logic [SLOT_IDX_W-1:0] in_slot_index,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [AREA_IDX_W-1:0] out_granted_area,
  output logic [SLOT_IDX_W-1:0] out_granted_slot,
  output logic [TOTAL_W-1:0]    out_total_used,
  output logic [TOTAL_W-1:0]    out_total_free,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SLOTS_W-1:0]    cfg_value
);

  localparam int AREA_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W     = (AREA_WORDS > 1) ? $clog2(AREA_WORDS) : 1;
  localparam int AREA_W     = (NUM_AREAS > 1) ? $clog2(NUM_AREAS) : 1;
  localparam int AC_W       = ($clog2(NUM_AREAS + 1) > AREA_CNT_W) ?
                              $clog2(NUM_AREAS + 1) : AREA_CNT_W;
  localparam int N_W        = ($clog2(MAX_SLOTS + 1) > SLOTS_W) ?
                              $clog2(MAX_SLOTS + 1) : SLOTS_W;
  localparam int SLOT_W     = WORD_W + BIT_W;
  localparam int CMP_W0     = (SLOT_W > N_W) ? SLOT_W : N_W;
  localparam int CMP_W      = (CMP_W0 > SLOT_IDX_W) ? CMP_W0 : SLOT_IDX_W;
  localparam int TOT_W      = (N_W + AREA_W > TOTAL_W + 1) ? N_W + AREA_W : TOTAL_W + 1;
  localparam int ADDR_W     = AREA_W + WORD_W;
  localparam int RAM_DEPTH  = 1 << ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_OPER,
    S_FREE_RD,
    S_ALLOC_AREA,
    S_SCAN,
    S_SUM
  } state_t;

  function automatic logic [N_W-1:0] eff_slots(
    input logic [AREA_W-1:0]                 a,
    input logic [REG_AREAS-1:0][SLOTS_W-1:0] slots
  );
    logic [N_W-1:0] n;
    n = '0;
    for (int k = 0; k < REG_AREAS; k++) begin
      if (k < NUM_AREAS && a == AREA_W'(k)) begin
        n = N_W'(slots[k]);
      end
    end
    if (n > N_W'(MAX_SLOTS)) begin
      n = N_W'(MAX_SLOTS);
    end
    return n;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_BITS-1:0] z);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (z[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  cfg_regs_t            cfg_regs;
  logic [NUM_AREAS-1:0] clr_req;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;

  state_t                state_r, state_nxt;
  logic [NUM_AREAS-1:0]  pend_r, pend_nxt;
  logic [WORD_W-1:0]     clr_word_r, clr_word_nxt;
  logic [WORD_W-1:0]     rd_word_r, rd_word_nxt;
  logic [AC_W-1:0]       a_r, a_nxt;
  logic [N_W-1:0]        used_r [NUM_AREAS];
  logic [N_W-1:0]        used_nxt [NUM_AREAS];
  logic                  op_r, op_nxt;
  logic [AREA_IDX_W-1:0] ai_r, ai_nxt;
  logic [SLOT_IDX_W-1:0] si_r, si_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [AREA_IDX_W-1:0] g_area_r, g_area_nxt;
  logic [SLOT_IDX_W-1:0] g_slot_r, g_slot_nxt;
  logic [TOT_W-1:0]      acc_u_r, acc_u_nxt;
  logic [TOT_W-1:0]      acc_f_r, acc_f_nxt;
  logic [TOTAL_W-1:0]    tot_u_r, tot_u_nxt;
  logic [TOTAL_W-1:0]    tot_f_r, tot_f_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [AC_W-1:0]       cnt;
  logic [AC_W-1:0]       ai_ext;
  logic [AREA_W-1:0]     ai_idx;
  logic [AREA_W-1:0]     a_idx;
  logic [AREA_W-1:0]     clr_area;
  logic [AREA_W-1:0]     area_sel;
  logic [N_W-1:0]        n_sel;
  logic [N_W-1:0]        used_sel;
  logic [N_W-1:0]        u_sel;
  logic [CMP_W-1:0]      si_ext;
  logic [WORD_BITS-1:0]  zmask;
  logic [BIT_W-1:0]      zbit;
  logic [CMP_W-1:0]      scan_slot;
  logic [TOT_W-1:0]      sum_u;
  logic [TOT_W-1:0]      sum_f;
  logic [NUM_AREAS-1:0]  pend_after;

  msba_cfg #(
    .NUM_AREAS (NUM_AREAS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_value (cfg_value),
    .regs      (cfg_regs),
    .clr_req   (clr_req)
  );

  msba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt    = (AC_W'(cfg_regs.area_count) > AC_W'(NUM_AREAS)) ?
                  AC_W'(NUM_AREAS) : AC_W'(cfg_regs.area_count);
  assign ai_ext = AC_W'(ai_r);
  assign ai_idx = ai_ext[AREA_W-1:0];
  assign a_idx  = a_r[AREA_W-1:0];
  assign si_ext = CMP_W'(si_r);

  always_comb begin
    clr_area = '0;
    for (int k = NUM_AREAS - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        clr_area = AREA_W'(k);
      end
    end
  end

  always_comb begin
    case (state_r)
      S_OPER, S_FREE_RD: area_sel = ai_idx;
      S_CLEAR:           area_sel = clr_area;
      default:           area_sel = a_idx;
    endcase
  end

  assign n_sel     = eff_slots(area_sel, cfg_regs.slots);
  assign used_sel  = used_r[area_sel];
  assign u_sel     = (used_sel > n_sel) ? n_sel : used_sel;
  assign zmask     = ~ram_rdata;
  assign zbit      = lowest_one(zmask);
  assign scan_slot = CMP_W'({rd_word_r, zbit});
  assign sum_u     = acc_u_r + TOT_W'(u_sel);
  assign sum_f     = acc_f_r + TOT_W'(n_sel - u_sel);
  assign pend_after = (pend_r & ~(NUM_AREAS'(1) << clr_area)) | clr_req;

  assign busy = (state_r != S_IDLE) || (pend_r != '0);

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r | clr_req;
    clr_word_nxt  = clr_word_r;
    rd_word_nxt   = rd_word_r;
    a_nxt         = a_r;
    used_nxt      = used_r;
    op_nxt        = op_r;
    ai_nxt        = ai_r;
    si_nxt        = si_r;
    status_nxt    = status_r;
    g_area_nxt    = g_area_r;
    g_slot_nxt    = g_slot_r;
    acc_u_nxt     = acc_u_r;
    acc_f_nxt     = acc_f_r;
    tot_u_nxt     = tot_u_r;
    tot_f_nxt     = tot_f_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (pend_r != '0) begin
          clr_word_nxt = '0;
          state_nxt    = S_CLEAR;
        end else if (start) begin
          op_nxt     = in_op;
          ai_nxt     = in_area_index;
          si_nxt     = in_slot_index;
          g_area_nxt = '0;
          g_slot_nxt = '0;
          state_nxt  = S_OPER;
        end
      end

      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = {clr_area, clr_word_r};
        ram_wdata    = '0;
        clr_word_nxt = clr_word_r + WORD_W'(1);
        if (&clr_word_r) begin
          pend_nxt = pend_after;
          if (pend_after == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_OPER: begin
        a_nxt     = '0;
        acc_u_nxt = '0;
        acc_f_nxt = '0;
        if (!cfg_regs.enable) begin
          status_nxt = STAT_DISABLED;
          state_nxt  = S_SUM;
        end else if (!op_r) begin
          state_nxt = S_ALLOC_AREA;
        end else if (ai_ext >= cnt) begin
          status_nxt = STAT_BAD_AREA;
          state_nxt  = S_SUM;
        end else if (si_ext >= CMP_W'(n_sel)) begin
          status_nxt = STAT_BAD_SLOT;
          state_nxt  = S_SUM;
        end else begin
          ram_raddr = {ai_idx, si_ext[WORD_W+BIT_W-1:BIT_W]};
          state_nxt = S_FREE_RD;
        end
      end

      S_FREE_RD: begin
        if (!ram_rdata[si_r[BIT_W-1:0]]) begin
          status_nxt = STAT_NOT_ALLOC;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = {ai_idx, si_ext[WORD_W+BIT_W-1:BIT_W]};
          ram_wdata  = ram_rdata & ~(WORD_BITS'(1) << si_r[BIT_W-1:0]);
          if (used_sel != '0) begin
            used_nxt[area_sel] = used_sel - N_W'(1);
          end
          status_nxt = STAT_OK;
        end
        state_nxt = S_SUM;
      end

      S_ALLOC_AREA: begin
        if (a_r >= cnt) begin
          status_nxt = STAT_FULL;
          a_nxt      = '0;
          state_nxt  = S_SUM;
        end else if (used_sel >= n_sel) begin
          a_nxt = a_r + AC_W'(1);
        end else begin
          ram_raddr   = {a_idx, WORD_W'(0)};
          rd_word_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        if (zmask != '0) begin
          if (scan_slot < CMP_W'(n_sel)) begin
            ram_we             = 1'b1;
            ram_waddr          = {a_idx, rd_word_r};
            ram_wdata          = ram_rdata | (WORD_BITS'(1) << zbit);
            used_nxt[area_sel] = used_sel + N_W'(1);
            status_nxt         = STAT_OK;
            g_area_nxt         = a_r[AREA_IDX_W-1:0];
            g_slot_nxt         = scan_slot[SLOT_IDX_W-1:0];
            a_nxt              = '0;
            state_nxt          = S_SUM;
          end else begin
            a_nxt     = a_r + AC_W'(1);
            state_nxt = S_ALLOC_AREA;
          end
        end else if (rd_word_r == WORD_W'(AREA_WORDS - 1)) begin
          a_nxt     = a_r + AC_W'(1);
          state_nxt = S_ALLOC_AREA;
        end else begin
          ram_raddr   = {a_idx, rd_word_r + WORD_W'(1)};
          rd_word_nxt = rd_word_r + WORD_W'(1);
        end
      end

      S_SUM: begin
        if (a_r < cnt) begin
          acc_u_nxt = sum_u;
          acc_f_nxt = sum_f;
        end
        if (a_r == AC_W'(NUM_AREAS - 1)) begin
          tot_u_nxt = (acc_u_nxt > TOT_W'(TOTAL_MAX)) ? TOTAL_MAX :
                      acc_u_nxt[TOTAL_W-1:0];
          tot_f_nxt = (acc_f_nxt > TOT_W'(TOTAL_MAX)) ? TOTAL_MAX :
                      acc_f_nxt[TOTAL_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          a_nxt = a_r + AC_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    for (int k = 0; k < NUM_AREAS; k++) begin
      if (clr_req[k]) begin
        used_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '1;
      clr_word_r  <= '0;
      a_r         <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_AREAS; k++) begin
        used_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      clr_word_r  <= clr_word_nxt;
      a_r         <= a_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      rd_word_r   <= rd_word_nxt;
      op_r        <= op_nxt;
      ai_r        <= ai_nxt;
      si_r        <= si_nxt;
      status_r    <= status_nxt;
      g_area_r    <= g_area_nxt;
      g_slot_r    <= g_slot_nxt;
      acc_u_r     <= acc_u_nxt;
      acc_f_r     <= acc_f_nxt;
      tot_u_r     <= tot_u_nxt;
      tot_f_r     <= tot_f_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_granted_area = g_area_r;
  assign out_granted_slot = g_slot_r;
  assign out_total_used   = tot_u_r;
  assign out_total_free   = tot_f_r;

  a_strobe_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_SUM))
    else $error("result strobe without a totals pass");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("bitmap write while idle");

  a_scan_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (a_r < cnt))
    else $error("scan of an area not in use");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |->
      (out_granted_area == '0 && out_granted_slot == '0))
    else $error("grant reported on a failed item");

endmodule

>>> design/msba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/msba_cfg.sv
// Configuration registers and per-area empty requests.
module msba_cfg import msba_pkg::*; #(
  parameter int NUM_AREAS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLOTS_W-1:0]   cfg_value,
  output cfg_regs_t            regs,
  output logic [NUM_AREAS-1:0] clr_req
);

  localparam int CLR_AREAS = (NUM_AREAS < REG_AREAS) ? NUM_AREAS : REG_AREAS;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    clr_req  = '0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SWAP_ENABLE: begin
          regs_nxt.enable = cfg_value[0];
        end
        CFG_AREA_COUNT: begin
          regs_nxt.area_count = cfg_value[AREA_CNT_W-1:0];
        end
        default: begin
          for (int k = 0; k < REG_AREAS; k++) begin
            if (cfg_index == CFG_AREA0_SLOTS + CFG_IDX_W'(k)) begin
              regs_nxt.slots[k] = cfg_value;
            end
          end
          for (int k = 0; k < CLR_AREAS; k++) begin
            if (cfg_index == CFG_AREA0_SLOTS + CFG_IDX_W'(k)) begin
              clr_req[k] = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

>>> verif/msba_checker.sv
// Scoreboard for the slot allocator: predicts every result and compares it on the strobe.
`timescale 1ns / 1ps
package msba_tb_pkg;
  import msba_pkg::*;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_AREA0_SLOTS + REG_AREAS;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_AREA0_SLOTS + REG_AREAS + 1;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [AREA_IDX_W-1:0] area;
    logic [SLOT_IDX_W-1:0] slot;
    logic [TOTAL_W-1:0]    used;
    logic [TOTAL_W-1:0]    free_cnt;
  } alloc_result_t;
endpackage

module msba_checker import msba_pkg::*; import msba_tb_pkg::*; #(
  parameter int NUM_AREAS = 4,
  parameter int MAX_SLOTS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_op,
  input  logic [AREA_IDX_W-1:0] in_area_index,
  input  logic [SLOT_IDX_W-1:0] in_slot_index,
  input  logic                  out_valid,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [AREA_IDX_W-1:0] out_granted_area,
  input  logic [SLOT_IDX_W-1:0] out_granted_slot,
  input  logic [TOTAL_W-1:0]    out_total_used,
  input  logic [TOTAL_W-1:0]    out_total_free,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SLOTS_W-1:0]    cfg_value,
  output int                    fail_count,
  output int                    pending
);

  logic                  sw_enable;
  logic [AREA_CNT_W-1:0] area_cnt_reg;
  logic [SLOTS_W-1:0]    slots_reg [REG_AREAS];
  logic [MAX_SLOTS-1:0]  slot_map [NUM_AREAS];
  int                    used_cnt [NUM_AREAS];
  alloc_result_t         expected_results [$];
  int                    mismatches;

  function automatic int area_size(int a);
    if (a >= REG_AREAS || a >= NUM_AREAS) return 0;
    return (slots_reg[a] > MAX_SLOTS) ? MAX_SLOTS : int'(slots_reg[a]);
  endfunction

  function automatic int areas_active();
    return (area_cnt_reg > NUM_AREAS) ? NUM_AREAS : int'(area_cnt_reg);
  endfunction

  function automatic void clear_model();
    sw_enable = 1'b0;
    area_cnt_reg = '0;
    for (int a = 0; a < REG_AREAS; a++) slots_reg[a] = '0;
    for (int a = 0; a < NUM_AREAS; a++) begin
      slot_map[a] = '0;
      used_cnt[a] = 0;
    end
    expected_results.delete();
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx, logic [SLOTS_W-1:0] val);
    int a;
    a = int'(idx) - int'(CFG_AREA0_SLOTS);
    if (idx == CFG_SWAP_ENABLE) begin
      sw_enable = val[0];
    end else if (idx == CFG_AREA_COUNT) begin
      area_cnt_reg = val[AREA_CNT_W-1:0];
    end else if (a >= 0 && a < REG_AREAS) begin
      slots_reg[a] = val;
      if (a < NUM_AREAS) begin
        slot_map[a] = '0;
        used_cnt[a] = 0;
      end
    end
  endfunction

  function automatic alloc_result_t serve_request(logic op, logic [AREA_IDX_W-1:0] ai,
                                                  logic [SLOT_IDX_W-1:0] si);
    alloc_result_t r;
    int cnt, a, n, s, u, used_sum, free_sum;
    cnt = areas_active();
    r = '0;
    r.status = STAT_OK;
    if (!sw_enable) begin
      r.status = STAT_DISABLED;
    end else if (op == OP_ALLOC) begin
      r.status = STAT_FULL;
      for (a = 0; a < cnt && r.status == STAT_FULL; a++) begin
        n = area_size(a);
        if (used_cnt[a] < n) begin
          s = 0;
          while (s < n && slot_map[a][s]) s++;
          if (s < n) begin
            slot_map[a][s] = 1'b1;
            used_cnt[a]++;
            r.status = STAT_OK;
            r.area = a[AREA_IDX_W-1:0];
            r.slot = s[SLOT_IDX_W-1:0];
          end
        end
      end
    end else if (int'(ai) >= cnt) begin
      r.status = STAT_BAD_AREA;
    end else if (int'(si) >= area_size(ai)) begin
      r.status = STAT_BAD_SLOT;
    end else if (!slot_map[ai][si]) begin
      r.status = STAT_NOT_ALLOC;
    end else begin
      slot_map[ai][si] = 1'b0;
      if (used_cnt[ai] > 0) used_cnt[ai]--;
    end

    used_sum = 0;
    free_sum = 0;
    for (a = 0; a < cnt; a++) begin
      n = area_size(a);
      u = (used_cnt[a] > n) ? n : used_cnt[a];
      used_sum += u;
      free_sum += n - u;
    end
    r.used = (used_sum > int'(TOTAL_MAX)) ? TOTAL_MAX : used_sum[TOTAL_W-1:0];
    r.free_cnt = (free_sum > int'(TOTAL_MAX)) ? TOTAL_MAX : free_sum[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic void report(string what, alloc_result_t want, alloc_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp st=%0d area=%0d slot=%0d used=%0d free=%0d | got st=%0d area=%0d slot=%0d used=%0d free=%0d",
               $realtime, what, want.status, want.area, want.slot, want.used, want.free_cnt,
               got.status, got.area, got.slot, got.used, got.free_cnt);
  endfunction

  function automatic void check_result();
    alloc_result_t want, got;
    got = {out_status, out_granted_area, out_granted_slot, out_total_used, out_total_free};
    if (expected_results.size() == 0) begin
      report("unexpected result", '0, got);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status || got.area !== want.area || got.slot !== want.slot ||
          got.used !== want.used || got.free_cnt !== want.free_cnt)
        report("result mismatch", want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      mismatches = 0;
    end else begin
      if (out_valid) check_result();
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_value);
      if (start && !busy)
        expected_results.push_back(serve_request(in_op, in_area_index, in_slot_index));
    end
    fail_count <= mismatches;
    pending <= expected_results.size();
  end

endmodule

>>> verif/multi_area_slot_bitmap_allocator_test.sv
// Top-level bench for the slot allocator: drives requests and register writes, gives the verdict.
`timescale 1ns / 1ps
module multi_area_slot_bitmap_allocator_test;
  import msba_pkg::*;
  import msba_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 2_500_000;
  localparam int DRAIN_CYCLES = 600;
  localparam int MAX_SLOTS    = 4096;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_op;
  logic [AREA_IDX_W-1:0] in_area_index;
  logic [SLOT_IDX_W-1:0] in_slot_index;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [AREA_IDX_W-1:0] out_granted_area;
  logic [SLOT_IDX_W-1:0] out_granted_slot;
  logic [TOTAL_W-1:0]    out_total_used;
  logic [TOTAL_W-1:0]    out_total_free;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SLOTS_W-1:0]    cfg_value;
  int                    fail_count;
  int                    pending;

  int                    cycle_cnt = 0;
  int                    items_sent = 0;
  bit                    quiet_run = 1'b0;
  logic [SLOTS_W-1:0]    size_written [REG_AREAS];
  logic [AREA_CNT_W-1:0] count_written;

  multi_area_slot_bitmap_allocator u_top (.*);

  msba_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [AREA_IDX_W-1:0] ai, logic [SLOT_IDX_W-1:0] si);
    if (!quiet_run && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_area_index <= ai;
    in_slot_index <= si;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SLOTS_W-1:0] val);
    int a;
    a = int'(idx) - int'(CFG_AREA0_SLOTS);
    if (!quiet_run && $urandom_range(99) < 36) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_AREA_COUNT) count_written = val[AREA_CNT_W-1:0];
    else if (a >= 0 && a < REG_AREAS) size_written[a] = val;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_setup();
    logic [SLOTS_W-1:0] val;
    wait_drained();
    val = SLOTS_W'($urandom);
    val[0] = ($urandom_range(9) != 0);
    write_reg(CFG_SWAP_ENABLE, val);
    val = SLOTS_W'($urandom);
    val[AREA_CNT_W-1:0] = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    write_reg(CFG_AREA_COUNT, val);
    for (int a = 0; a < REG_AREAS; a++) begin
      if ($urandom_range(9) < 6) begin
        val = ($urandom_range(15) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 48);
        write_reg(CFG_AREA0_SLOTS + a, val);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    int pick, cnt, n;
    logic [AREA_IDX_W-1:0] ai;
    logic [SLOT_IDX_W-1:0] si;
    pick = $urandom_range(99);
    cnt = (count_written > REG_AREAS) ? REG_AREAS : int'(count_written);
    ai = $urandom;
    si = $urandom;
    if (pick < 55) begin
      send_item(OP_ALLOC, ai, si);
    end else if (pick < 85 && cnt > 0) begin
      ai = $urandom_range(cnt - 1);
      n = (size_written[ai] > MAX_SLOTS) ? MAX_SLOTS : int'(size_written[ai]);
      if (n > 0) si = $urandom_range(n - 1);
      send_item(OP_FREE, ai, si);
    end else begin
      send_item(OP_FREE, ai, si);
    end
  endtask

  initial begin
    int phase_len;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= OP_ALLOC;
    in_area_index <= '0;
    in_slot_index <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SWAP_ENABLE;
    cfg_value <= '0;
    count_written = '0;
    for (int a = 0; a < REG_AREAS; a++) size_written[a] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_FREE, 2'd3, 12'd4095);
    wait_drained();

    write_reg(CFG_SWAP_ENABLE, 13'd1);
    write_reg(CFG_AREA_COUNT, 13'd4);
    write_reg(CFG_AREA0_SLOTS, 13'd2);
    write_reg(CFG_AREA0_SLOTS + 1, 13'd0);
    write_reg(CFG_AREA0_SLOTS + 2, 13'd3);
    write_reg(CFG_AREA0_SLOTS + 3, 13'h1FFF);
    cfg_valid <= 1'b0;
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_FREE, 2'd0, 12'd1);
    send_item(OP_FREE, 2'd0, 12'd1);
    send_item(OP_FREE, 2'd0, 12'd2);
    send_item(OP_FREE, 2'd3, 12'd4095);
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_FREE, 2'd3, 12'd0);
    send_item(OP_FREE, 2'd2, 12'd4095);
    wait_drained();

    write_reg(CFG_AREA_COUNT, 13'd2);
    cfg_valid <= 1'b0;
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_FREE, 2'd2, 12'd0);
    send_item(OP_FREE, 2'd3, 12'd4095);
    wait_drained();

    write_reg(CFG_AREA_COUNT, 13'h1FFF);
    write_reg(CFG_AREA0_SLOTS, 13'd2);
    cfg_valid <= 1'b0;
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_ALLOC, $urandom, $urandom);
    wait_drained();

    write_reg(CFG_SWAP_ENABLE, 13'h1FFE);
    write_reg(CFG_SPARE_LO, 13'd1);
    write_reg(CFG_SPARE_HI, 13'h1FFF);
    cfg_valid <= 1'b0;
    send_item(OP_ALLOC, $urandom, $urandom);
    send_item(OP_FREE, 2'd0, 12'd0);

    for (int phase = 0; items_sent < RANDOM_ITEMS + 24; phase++) begin
      quiet_run = (phase == 3);
      random_setup();
      phase_len = $urandom_range(30, 90);
      for (int i = 0; i < phase_len; i++) send_random_item();
    end
    quiet_run = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
